// ===== sv/cdt_pkg.sv =====
// cdt_pkg: shared types, codes and width constants for the countdown timer controller
// no dependencies; imported by cdt_step, countdown_timer_event_fsm_unit and the bench
`default_nettype none

package cdt_pkg;

    // widths of the time counters
    localparam int TIME_BITS  = 16;
    localparam int TOTAL_BITS = 24;

    // fixed field widths
    localparam int OP_BITS     = 3;
    localparam int PHASE_BITS  = 4;
    localparam int STATUS_BITS = 2;
    localparam int MODE_BITS   = 3;
    localparam int SHOWN_BITS  = 24;
    localparam int MSG_BITS    = 2;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 4;

    // one minute step and the largest whole-minute set time
    localparam longint unsigned STEP_SECONDS = 60;
    localparam longint unsigned TIME_MAX_L   = (64'd1 << TIME_BITS) - 64'd1;
    localparam longint unsigned TIME_TOP_L   = (TIME_MAX_L / STEP_SECONDS) * STEP_SECONDS;
    localparam logic [TIME_BITS-1:0] TIME_STEP = TIME_BITS'(STEP_SECONDS);
    localparam logic [TIME_BITS-1:0] TIME_TOP  = TIME_BITS'(TIME_TOP_L);
    localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    // width of the total plus elapsed sum, one carry bit above the wider operand
    localparam int SUM_BITS = ((TIME_BITS > TOTAL_BITS) ? TIME_BITS : TOTAL_BITS) + 1;

    // mode codes
    localparam logic [MODE_BITS-1:0] MODE_IDLE  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_SET   = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_RUN   = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_PAUSE = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_STATS = 3'd4;

    // event codes
    localparam logic [OP_BITS-1:0] OP_ENTRY      = 3'd0;
    localparam logic [OP_BITS-1:0] OP_EXIT       = 3'd1;
    localparam logic [OP_BITS-1:0] OP_INC        = 3'd2;
    localparam logic [OP_BITS-1:0] OP_DEC        = 3'd3;
    localparam logic [OP_BITS-1:0] OP_STARTPAUSE = 3'd4;
    localparam logic [OP_BITS-1:0] OP_ABORT      = 3'd5;
    localparam logic [OP_BITS-1:0] OP_TICK       = 3'd6;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_IGNORED    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_HANDLED    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_TRANSITION = 2'd2;

    // message codes
    localparam logic [MSG_BITS-1:0] MSG_NONE       = 2'd0;
    localparam logic [MSG_BITS-1:0] MSG_SET_TIME   = 2'd1;
    localparam logic [MSG_BITS-1:0] MSG_PAUSED     = 2'd2;
    localparam logic [MSG_BITS-1:0] MSG_PRODUCTIVE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BEEP_PHASE   = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_PHASE = 1'd1;

    typedef struct packed {
        logic [MODE_BITS-1:0]  mode;
        logic [TIME_BITS-1:0]  set_seconds;
        logic [TIME_BITS-1:0]  run_seconds;
        logic [TOTAL_BITS-1:0] total_seconds;
    } t_state;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [MODE_BITS-1:0]   state_now;
        logic                   show_time;
        logic [SHOWN_BITS-1:0]  time_shown;
        logic [MSG_BITS-1:0]    message_code;
        logic                   clear_display;
        logic                   beep;
    } t_result;

    typedef struct packed {
        logic [PHASE_BITS-1:0] beep_phase;
        logic [PHASE_BITS-1:0] second_phase;
    } t_cfg;

    // add one minute, held at the largest whole-minute value
    function automatic logic [TIME_BITS-1:0] add_minute(input logic [TIME_BITS-1:0] t);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, t} + {1'b0, TIME_STEP};
        if (sum > {1'b0, TIME_TOP}) begin
            return TIME_TOP;
        end
        return sum[TIME_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/cdt_step.sv =====
// cdt_step: event decode and state update for one event, purely combinational
// depends on cdt_pkg
`default_nettype none

module cdt_step (
    input  wire cdt_pkg::t_state            i_state,
    input  wire cdt_pkg::t_cfg              i_cfg,
    input  wire [cdt_pkg::OP_BITS-1:0]      i_op,
    input  wire [cdt_pkg::PHASE_BITS-1:0]   i_phase,
    output cdt_pkg::t_state                 o_state,
    output cdt_pkg::t_result                o_result
);
    import cdt_pkg::*;

    logic                  beep_tick;
    logic                  sec_tick;
    logic                  set_ge_step;
    logic [TIME_BITS-1:0]  set_inc;
    logic [TIME_BITS-1:0]  set_dec;
    logic [TIME_BITS-1:0]  set_count;
    logic [TIME_BITS-1:0]  run_count;
    logic [SUM_BITS-1:0]   total_sum;
    logic [TOTAL_BITS-1:0] total_sat;

    assign beep_tick   = (i_op == OP_TICK) && (i_phase == i_cfg.beep_phase);
    assign sec_tick    = (i_op == OP_TICK) && (i_phase == i_cfg.second_phase);
    assign set_ge_step = (i_state.set_seconds >= TIME_STEP);
    assign set_inc     = add_minute(i_state.set_seconds);
    assign set_dec     = i_state.set_seconds - TIME_STEP;
    // countdown holds at zero
    assign set_count   = (i_state.set_seconds != '0) ? i_state.set_seconds - 1'b1 : '0;
    assign run_count   = (i_state.run_seconds != TIME_MAX) ?
                         i_state.run_seconds + 1'b1 : TIME_MAX;
    assign total_sum   = SUM_BITS'(i_state.total_seconds) + SUM_BITS'(i_state.run_seconds);
    assign total_sat   = (total_sum > SUM_BITS'(TOTAL_MAX)) ?
                         TOTAL_MAX : total_sum[TOTAL_BITS-1:0];

    always_comb begin
        o_state                = i_state;
        o_result.status        = ST_IGNORED;
        o_result.show_time     = 1'b0;
        o_result.time_shown    = '0;
        o_result.message_code  = MSG_NONE;
        o_result.clear_display = 1'b0;
        o_result.beep          = 1'b0;

        unique case (i_state.mode)
            MODE_IDLE: begin
                priority if (i_op == OP_ENTRY) begin
                    o_state.set_seconds   = '0;
                    o_state.run_seconds   = '0;
                    o_result.show_time    = 1'b1;
                    o_result.message_code = MSG_SET_TIME;
                    o_result.status       = ST_HANDLED;
                end else if (i_op == OP_EXIT) begin
                    o_result.clear_display = 1'b1;
                    o_result.status        = ST_HANDLED;
                end else if (i_op == OP_INC) begin
                    o_state.set_seconds = set_inc;
                    o_state.mode        = MODE_SET;
                    o_result.status     = ST_TRANSITION;
                end else if (i_op == OP_STARTPAUSE) begin
                    o_state.mode    = MODE_STATS;
                    o_result.status = ST_TRANSITION;
                end else if (beep_tick) begin
                    o_result.beep   = 1'b1;
                    o_result.status = ST_HANDLED;
                end else begin
                end
            end
            MODE_SET: begin
                priority if (i_op == OP_ENTRY) begin
                    o_result.show_time  = 1'b1;
                    o_result.time_shown = SHOWN_BITS'(i_state.set_seconds);
                    o_result.status     = ST_HANDLED;
                end else if (i_op == OP_EXIT) begin
                    o_result.clear_display = 1'b1;
                    o_result.status        = ST_HANDLED;
                end else if (i_op == OP_INC) begin
                    o_state.set_seconds = set_inc;
                    o_result.show_time  = 1'b1;
                    o_result.time_shown = SHOWN_BITS'(set_inc);
                    o_result.status     = ST_HANDLED;
                end else if (i_op == OP_DEC && set_ge_step) begin
                    o_state.set_seconds = set_dec;
                    o_result.show_time  = 1'b1;
                    o_result.time_shown = SHOWN_BITS'(set_dec);
                    o_result.status     = ST_HANDLED;
                end else if (i_op == OP_STARTPAUSE && set_ge_step) begin
                    o_state.mode    = MODE_RUN;
                    o_result.status = ST_TRANSITION;
                end else if (i_op == OP_ABORT) begin
                    o_state.mode    = MODE_IDLE;
                    o_result.status = ST_TRANSITION;
                end else begin
                end
            end
            MODE_RUN: begin
                priority if (i_op == OP_EXIT) begin
                    o_state.total_seconds = total_sat;
                    o_state.run_seconds   = '0;
                    o_result.status       = ST_HANDLED;
                end else if (i_op == OP_STARTPAUSE) begin
                    o_state.mode    = MODE_PAUSE;
                    o_result.status = ST_TRANSITION;
                end else if (sec_tick) begin
                    o_state.set_seconds = set_count;
                    o_state.run_seconds = run_count;
                    o_result.show_time  = 1'b1;
                    o_result.time_shown = SHOWN_BITS'(set_count);
                    if (set_count == '0) begin
                        o_state.mode    = MODE_IDLE;
                        o_result.status = ST_TRANSITION;
                    end else begin
                        o_result.status = ST_HANDLED;
                    end
                end else begin
                end
            end
            MODE_PAUSE: begin
                priority if (i_op == OP_ENTRY) begin
                    o_result.message_code = MSG_PAUSED;
                    o_result.status       = ST_HANDLED;
                end else if (i_op == OP_EXIT) begin
                    o_result.clear_display = 1'b1;
                    o_result.status        = ST_HANDLED;
                end else if (i_op == OP_INC) begin
                    o_state.set_seconds = set_inc;
                    o_state.mode        = MODE_SET;
                    o_result.status     = ST_TRANSITION;
                end else if (i_op == OP_DEC && set_ge_step) begin
                    o_state.set_seconds = set_dec;
                    o_state.mode        = MODE_SET;
                    o_result.status     = ST_TRANSITION;
                end else if (i_op == OP_STARTPAUSE) begin
                    o_state.mode    = MODE_RUN;
                    o_result.status = ST_TRANSITION;
                end else if (i_op == OP_ABORT) begin
                    o_state.mode    = MODE_IDLE;
                    o_result.status = ST_TRANSITION;
                end else begin
                end
            end
            MODE_STATS: begin
                priority if (i_op == OP_ENTRY) begin
                    o_result.show_time    = 1'b1;
                    o_result.time_shown   = SHOWN_BITS'(i_state.total_seconds);
                    o_result.message_code = MSG_PRODUCTIVE;
                    o_result.status       = ST_HANDLED;
                end else if (i_op == OP_EXIT) begin
                    o_result.clear_display = 1'b1;
                    o_result.status        = ST_HANDLED;
                end else if (sec_tick) begin
                    o_state.mode    = MODE_IDLE;
                    o_result.status = ST_TRANSITION;
                end else begin
                end
            end
            default: begin
                // unused mode codes: ignore everything, hold the mode
            end
        endcase

        o_result.state_now = o_state.mode;
    end

endmodule

`default_nettype wire

// ===== sv/countdown_timer_event_fsm_unit.sv =====
// countdown_timer_event_fsm_unit: top level of the countdown timer controller
// depends on cdt_pkg and cdt_step
//
// One event in, one result out. An accepted event lands in an input register; once the
// input register moves on, cdt_step decodes it against the current mode and counters,
// the counters update and the result is written to the output register. A new event
// is taken every cycle while the input is not stalled. The output register decouples
// the two sides: an event can be accepted while the previous result waits, and only a
// stalled, full output register with a full input register holds the input off. The
// beep and second phases are written through the plain register port and should only
// change while no event is in flight.
`default_nettype none

module countdown_timer_event_fsm_unit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,

    // configuration writes
    input  wire                                  i_cfg_we,
    input  wire [cdt_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire [cdt_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,

    // event channel
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire [cdt_pkg::OP_BITS-1:0]           i_operation,
    input  wire [cdt_pkg::PHASE_BITS-1:0]        i_tick_phase,

    // result channel
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic [cdt_pkg::STATUS_BITS-1:0]      o_status,
    output logic [cdt_pkg::MODE_BITS-1:0]        o_state_now,
    output logic                                 o_show_time,
    output logic [cdt_pkg::SHOWN_BITS-1:0]       o_time_shown,
    output logic [cdt_pkg::MSG_BITS-1:0]         o_message_code,
    output logic                                 o_clear_display,
    output logic                                 o_beep
);
    import cdt_pkg::*;

    // configuration registers
    t_cfg                  r_cfg;

    // input register
    logic                  r_in_valid;
    logic [OP_BITS-1:0]    r_in_op;
    logic [PHASE_BITS-1:0] r_in_phase;

    // controller state
    t_state                r_state;
    t_state                n_state;

    // output register
    logic                  r_out_valid;
    t_result               r_out;
    t_result               n_out;

    logic                  advance;
    logic                  in_xfer;

    // the input register moves on when the output register is empty or being taken
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    cdt_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_op     (r_in_op),
        .i_phase  (r_in_phase),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // configuration, beep and second phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.beep_phase   <= 4'd5;
            r_cfg.second_phase <= 4'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BEEP_PHASE:   r_cfg.beep_phase   <= i_cfg_data;
                CFG_SECOND_PHASE: r_cfg.second_phase <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload, captured on each transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_op    <= i_operation;
            r_in_phase <= i_tick_phase;
        end
    end

    // mode and counters update as the event moves into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode          <= MODE_IDLE;
            r_state.set_seconds   <= '0;
            r_state.run_seconds   <= '0;
            r_state.total_seconds <= '0;
        end else if (r_in_valid && advance) begin
            r_state <= n_state;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_state_now     = r_out.state_now;
    assign o_show_time     = r_out.show_time;
    assign o_time_shown    = r_out.time_shown;
    assign o_message_code  = r_out.message_code;
    assign o_clear_display = r_out.clear_display;
    assign o_beep          = r_out.beep;

endmodule

`default_nettype wire

// ===== dv/tb_countdown_timer_event_fsm_unit.sv =====
// tb_countdown_timer_event_fsm_unit: self-checking bench for the countdown timer controller
// an in-bench timer model predicts every response; stimulus is directed and random
// depends on cdt_pkg and countdown_timer_event_fsm_unit
`default_nettype none

module tb_countdown_timer_event_fsm_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cdt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int HOLD_CYCLES    = 60;
    localparam int CFG_SETTLE     = 4;

    // event code with no meaning, ignored in every state
    localparam logic [OP_BITS-1:0] OP_UNKNOWN = 3'd7;

    // clock, reset and dut ports; the bench-driven ones at known values from time zero
    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_cfg_we     = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index  = CFG_BEEP_PHASE;
    logic [CFG_DATA_BITS-1:0] i_cfg_data   = '0;
    logic                     i_in_valid   = 1'b0;
    logic                     o_in_stall;
    logic [OP_BITS-1:0]       i_operation  = OP_ENTRY;
    logic [PHASE_BITS-1:0]    i_tick_phase = '0;
    logic                     o_out_valid;
    logic                     i_out_stall  = 1'b0;
    logic [STATUS_BITS-1:0]   o_status;
    logic [MODE_BITS-1:0]     o_state_now;
    logic                     o_show_time;
    logic [SHOWN_BITS-1:0]    o_time_shown;
    logic [MSG_BITS-1:0]      o_message_code;
    logic                     o_clear_display;
    logic                     o_beep;

    // timer model: mode, counters and phase registers as the bench believes them
    logic [MODE_BITS-1:0]  timer_mode      = MODE_IDLE;
    logic [TIME_BITS-1:0]  set_secs        = '0;
    logic [TIME_BITS-1:0]  elapsed_secs    = '0;
    logic [TOTAL_BITS-1:0] productive_secs = '0;
    t_cfg                  phase_cfg       = '{beep_phase: 4'd5, second_phase: 4'd10};

    // responses owed by the dut, oldest first
    t_result responses_due [$];

    // traffic shaping shared by the sender, the receiver and the tests
    bit src_idle_en  = 1'b0;
    bit sink_idle_en = 1'b0;
    bit hold_req     = 1'b0;

    int events_sent = 0;
    int mismatches  = 0;
    int strays      = 0;
    int reports     = 0;

    t_result observed;
    t_result wanted;

    always #5 i_clk = ~i_clk;

    countdown_timer_event_fsm_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_tick_phase    (i_tick_phase),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_state_now     (o_state_now),
        .o_show_time     (o_show_time),
        .o_time_shown    (o_time_shown),
        .o_message_code  (o_message_code),
        .o_clear_display (o_clear_display),
        .o_beep          (o_beep)
    );

    // one minute up, held at the largest whole-minute set time
    function automatic logic [TIME_BITS-1:0] plus_minute(input logic [TIME_BITS-1:0] t);
        if (longint'(t) + longint'(STEP_SECONDS) > longint'(TIME_TOP_L)) begin
            return TIME_TOP;
        end
        return t + TIME_STEP;
    endfunction

    // apply one event to the timer model and return the response it owes
    function automatic t_result timer_react(input logic [OP_BITS-1:0] op,
                                            input logic [PHASE_BITS-1:0] ph);
        t_result r;
        logic [SUM_BITS-1:0] sum;
        r = '0;
        r.status       = ST_IGNORED;
        r.message_code = MSG_NONE;
        case (timer_mode)
            MODE_IDLE: begin
                if (op == OP_ENTRY) begin
                    set_secs       = '0;
                    elapsed_secs   = '0;
                    r.show_time    = 1'b1;
                    r.message_code = MSG_SET_TIME;
                    r.status       = ST_HANDLED;
                end else if (op == OP_EXIT) begin
                    r.clear_display = 1'b1;
                    r.status        = ST_HANDLED;
                end else if (op == OP_INC) begin
                    set_secs   = plus_minute(set_secs);
                    timer_mode = MODE_SET;
                    r.status   = ST_TRANSITION;
                end else if (op == OP_STARTPAUSE) begin
                    timer_mode = MODE_STATS;
                    r.status   = ST_TRANSITION;
                end else if (op == OP_TICK && ph == phase_cfg.beep_phase) begin
                    r.beep   = 1'b1;
                    r.status = ST_HANDLED;
                end
            end
            MODE_SET: begin
                if (op == OP_ENTRY) begin
                    r.show_time  = 1'b1;
                    r.time_shown = SHOWN_BITS'(set_secs);
                    r.status     = ST_HANDLED;
                end else if (op == OP_EXIT) begin
                    r.clear_display = 1'b1;
                    r.status        = ST_HANDLED;
                end else if (op == OP_INC) begin
                    set_secs     = plus_minute(set_secs);
                    r.show_time  = 1'b1;
                    r.time_shown = SHOWN_BITS'(set_secs);
                    r.status     = ST_HANDLED;
                end else if (op == OP_DEC) begin
                    if (set_secs >= TIME_STEP) begin
                        set_secs     = set_secs - TIME_STEP;
                        r.show_time  = 1'b1;
                        r.time_shown = SHOWN_BITS'(set_secs);
                        r.status     = ST_HANDLED;
                    end
                end else if (op == OP_STARTPAUSE) begin
                    if (set_secs >= TIME_STEP) begin
                        timer_mode = MODE_RUN;
                        r.status   = ST_TRANSITION;
                    end
                end else if (op == OP_ABORT) begin
                    timer_mode = MODE_IDLE;
                    r.status   = ST_TRANSITION;
                end
            end
            MODE_RUN: begin
                if (op == OP_EXIT) begin
                    sum = SUM_BITS'(productive_secs) + SUM_BITS'(elapsed_secs);
                    productive_secs = (sum > SUM_BITS'(TOTAL_MAX)) ? TOTAL_MAX
                                                                   : sum[TOTAL_BITS-1:0];
                    elapsed_secs = '0;
                    r.status     = ST_HANDLED;
                end else if (op == OP_STARTPAUSE) begin
                    timer_mode = MODE_PAUSE;
                    r.status   = ST_TRANSITION;
                end else if (op == OP_TICK && ph == phase_cfg.second_phase) begin
                    if (set_secs != '0) begin
                        set_secs = set_secs - 1'b1;
                    end
                    if (elapsed_secs != TIME_MAX) begin
                        elapsed_secs = elapsed_secs + 1'b1;
                    end
                    r.show_time  = 1'b1;
                    r.time_shown = SHOWN_BITS'(set_secs);
                    if (set_secs == '0) begin
                        timer_mode = MODE_IDLE;
                        r.status   = ST_TRANSITION;
                    end else begin
                        r.status = ST_HANDLED;
                    end
                end
            end
            MODE_PAUSE: begin
                if (op == OP_ENTRY) begin
                    r.message_code = MSG_PAUSED;
                    r.status       = ST_HANDLED;
                end else if (op == OP_EXIT) begin
                    r.clear_display = 1'b1;
                    r.status        = ST_HANDLED;
                end else if (op == OP_INC) begin
                    set_secs   = plus_minute(set_secs);
                    timer_mode = MODE_SET;
                    r.status   = ST_TRANSITION;
                end else if (op == OP_DEC) begin
                    if (set_secs >= TIME_STEP) begin
                        set_secs   = set_secs - TIME_STEP;
                        timer_mode = MODE_SET;
                        r.status   = ST_TRANSITION;
                    end
                end else if (op == OP_STARTPAUSE) begin
                    timer_mode = MODE_RUN;
                    r.status   = ST_TRANSITION;
                end else if (op == OP_ABORT) begin
                    timer_mode = MODE_IDLE;
                    r.status   = ST_TRANSITION;
                end
            end
            MODE_STATS: begin
                if (op == OP_ENTRY) begin
                    r.show_time    = 1'b1;
                    r.time_shown   = SHOWN_BITS'(productive_secs);
                    r.message_code = MSG_PRODUCTIVE;
                    r.status       = ST_HANDLED;
                end else if (op == OP_EXIT) begin
                    r.clear_display = 1'b1;
                    r.status        = ST_HANDLED;
                end else if (op == OP_TICK && ph == phase_cfg.second_phase) begin
                    timer_mode = MODE_IDLE;
                    r.status   = ST_TRANSITION;
                end
            end
            default: begin
                // unused mode codes leave everything alone
            end
        endcase
        r.state_now = timer_mode;
        return r;
    endfunction

    function automatic string describe(input t_result r);
        return $sformatf("status=%0d state=%0d show=%0b time=%0d msg=%0d clear=%0b beep=%0b",
                         r.status, r.state_now, r.show_time, r.time_shown,
                         r.message_code, r.clear_display, r.beep);
    endfunction

    // tick phase biased towards the two programmed phases
    function automatic logic [PHASE_BITS-1:0] pick_phase();
        case ($urandom_range(0, 3))
            0:       return phase_cfg.beep_phase;
            1:       return phase_cfg.second_phase;
            default: return PHASE_BITS'($urandom_range(0, 15));
        endcase
    endfunction

    // offer one event, with an optional idle burst first, and book its response
    // valid is left high so that a following event goes out back to back
    task automatic send_event(input logic [OP_BITS-1:0] op, input logic [PHASE_BITS-1:0] ph);
        int gap;
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_tick_phase <= ph;
        do @(posedge i_clk); while (o_in_stall);
        responses_due.push_back(timer_react(op, ph));
        events_sent++;
    endtask

    task automatic send_noise();
        send_event(OP_BITS'($urandom_range(0, 7)), pick_phase());
    endtask

    // drop valid and wait for every owed response
    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (responses_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] val);
        quiesce();
        repeat (CFG_SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == CFG_BEEP_PHASE) begin
            phase_cfg.beep_phase = val;
        end else begin
            phase_cfg.second_phase = val;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // a realistic session: set a time, start, tick it down, with some noise mixed in
    task automatic countdown_episode();
        int ticks;
        ticks = $urandom_range(3, 75);
        if (timer_mode == MODE_STATS) begin
            send_event(OP_TICK, phase_cfg.second_phase);
        end
        if (timer_mode == MODE_IDLE && $urandom_range(0, 1) == 1) begin
            send_event(OP_ENTRY, PHASE_BITS'($urandom_range(0, 15)));
        end
        if (timer_mode != MODE_RUN) begin
            repeat ($urandom_range(1, 2)) send_event(OP_INC, PHASE_BITS'($urandom_range(0, 15)));
            if ($urandom_range(0, 3) == 0) begin
                send_event(OP_DEC, PHASE_BITS'($urandom_range(0, 15)));
            end
            send_event(OP_STARTPAUSE, PHASE_BITS'($urandom_range(0, 15)));
        end
        repeat (ticks) begin
            if ($urandom_range(0, 9) < 8) begin
                send_event(OP_TICK, phase_cfg.second_phase);
            end else begin
                send_noise();
            end
        end
        case ($urandom_range(0, 3))
            0:       send_event(OP_EXIT, PHASE_BITS'($urandom_range(0, 15)));
            1:       send_event(OP_STARTPAUSE, PHASE_BITS'($urandom_range(0, 15)));
            default: ;
        endcase
    endtask

    // mostly sessions, some loose noise
    task automatic mixed_traffic(input int count);
        int stop_at;
        stop_at = events_sent + count;
        while (events_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                countdown_episode();
            end else begin
                repeat ($urandom_range(1, 6)) send_noise();
            end
        end
    endtask

    // each state reached by hand and driven with a range of events, default phases
    task automatic test_directed();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        send_event(OP_ENTRY, 4'h0);
        send_event(OP_TICK, phase_cfg.beep_phase);
        send_event(OP_TICK, 4'hF);
        send_event(OP_EXIT, 4'h0);
        send_event(OP_DEC, 4'h0);
        send_event(OP_ABORT, 4'h0);
        send_event(OP_UNKNOWN, 4'hF);                // unknown code is ignored
        send_event(OP_INC, 4'h0);                    // idle to time set, 60 s
        send_event(OP_DEC, 4'h0);                    // back to zero
        send_event(OP_DEC, 4'h0);                    // under a minute: ignored
        send_event(OP_STARTPAUSE, 4'h0);             // no start under a minute
        send_event(OP_INC, 4'h0);
        send_event(OP_ENTRY, 4'h0);
        send_event(OP_UNKNOWN, 4'h0);
        send_event(OP_STARTPAUSE, 4'h0);             // into countdown
        send_event(OP_TICK, 4'h0);
        send_event(OP_TICK, phase_cfg.second_phase);
        send_event(OP_ENTRY, 4'h0);
        send_event(OP_STARTPAUSE, 4'h0);             // pause
        send_event(OP_ENTRY, 4'h0);
        send_event(OP_STARTPAUSE, 4'h0);             // resume and pause again
        send_event(OP_STARTPAUSE, 4'h0);
        send_event(OP_EXIT, 4'h0);
        send_event(OP_DEC, 4'h0);                    // 59 s left: ignored
        send_event(OP_INC, 4'h0);                    // pause to time set
        send_event(OP_ABORT, 4'h0);
        send_event(OP_STARTPAUSE, 4'h0);             // idle to stats
        send_event(OP_ENTRY, 4'h0);
        send_event(OP_TICK, phase_cfg.second_phase);
    endtask

    // a full one-minute countdown to zero, then elapsed time folded into the total
    task automatic test_countdown_to_zero();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        while (timer_mode != MODE_IDLE) begin
            case (timer_mode)
                MODE_RUN:   send_event(OP_STARTPAUSE, 4'h0);
                MODE_STATS: send_event(OP_TICK, phase_cfg.second_phase);
                default:    send_event(OP_ABORT, 4'h0);
            endcase
        end
        send_event(OP_ENTRY, 4'h0);
        send_event(OP_INC, 4'h0);
        send_event(OP_STARTPAUSE, 4'h0);
        while (timer_mode == MODE_RUN) send_event(OP_TICK, phase_cfg.second_phase);
        // elapsed carries over into a short second run
        send_event(OP_INC, 4'h0);
        send_event(OP_STARTPAUSE, 4'h0);
        repeat (10) send_event(OP_TICK, phase_cfg.second_phase);
        send_event(OP_EXIT, 4'h0);                   // fold into the productive total
        send_event(OP_STARTPAUSE, 4'h0);
        send_event(OP_ABORT, 4'h0);
        send_event(OP_STARTPAUSE, 4'h0);
        send_event(OP_ENTRY, 4'h0);
        send_event(OP_TICK, phase_cfg.second_phase);
    endtask

    // random traffic under several phase settings, the extremes among them
    task automatic test_phase_settings();
        logic [CFG_DATA_BITS-1:0] beep_list [5];
        logic [CFG_DATA_BITS-1:0] sec_list  [5];
        beep_list = '{4'd0, 4'd15, 4'd9, 4'd5, CFG_DATA_BITS'($urandom_range(0, 15))};
        sec_list  = '{4'd15, 4'd0, 4'd9, 4'd10, CFG_DATA_BITS'($urandom_range(0, 15))};
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        for (int k = 0; k < 5; k++) begin
            set_register(CFG_BEEP_PHASE, beep_list[k]);
            set_register(CFG_SECOND_PHASE, sec_list[k]);
            mixed_traffic(110);
        end
    endtask

    // long receiver hold while the sender keeps pushing, a full drain, then mixed traffic
    task automatic test_backpressure();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_req     = 1'b1;
        repeat (30) begin
            if ($urandom_range(0, 1) == 1) begin
                send_event(OP_TICK, phase_cfg.second_phase);
            end else begin
                send_noise();
            end
        end
        quiesce();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        mixed_traffic(40);
    endtask

    // closing stretch at full rate on both sides
    task automatic test_full_rate();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        mixed_traffic(80);
    endtask

    // receiver: random stall bursts, or one long counted hold on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // response checker: every transfer on the result side against the oldest owed response
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            observed = '{status: o_status, state_now: o_state_now, show_time: o_show_time,
                         time_shown: o_time_shown, message_code: o_message_code,
                         clear_display: o_clear_display, beep: o_beep};
            if (responses_due.size() == 0) begin
                strays++;
                if (reports < MAX_REPORTS) begin
                    $display("%0t: response with nothing owed: %s", $realtime, describe(observed));
                end
                reports++;
            end else begin
                wanted = responses_due.pop_front();
                if (observed !== wanted) begin
                    mismatches++;
                    if (reports < MAX_REPORTS) begin
                        $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                 $realtime, describe(wanted), describe(observed));
                    end
                    reports++;
                end
            end
        end
    end

    // watchdog: too long without any transfer means the run is stuck
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
                || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("** countdown_timer_event_fsm_unit: FAILED **");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_countdown_to_zero();
        test_phase_settings();
        test_backpressure();
        test_full_rate();

        quiesce();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && strays == 0 && responses_due.size() == 0) begin
            $display("** countdown_timer_event_fsm_unit: PASSED **");
        end else begin
            $display("** countdown_timer_event_fsm_unit: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
